// ===== hdl/bcc_pkg.sv =====
// shared types, widths, codes and reset values for the button click classifier
// no dependencies
`default_nettype none

package bcc_pkg;

	localparam int NOW_W      = 32;
	localparam int DEB_W      = 8;
	localparam int THR_W      = 16;
	localparam int EV_W       = 3;
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 16;

	localparam int HOLD_FACTOR_DEF = 5;

	localparam logic [DEB_W-1:0] DEB_RST   = DEB_W'(30);
	localparam logic [THR_W-1:0] SHORT_RST = THR_W'(100);
	localparam logic [THR_W-1:0] LONG_RST  = THR_W'(380);
	localparam logic [THR_W-1:0] DGAP_RST  = THR_W'(110);
	localparam logic             ALOW_RST  = 1'b0;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_DEBOUNCE   = 3'd0,
		REG_SHORT      = 3'd1,
		REG_LONG       = 3'd2,
		REG_DOUBLE_GAP = 3'd3,
		REG_ACTIVE_LOW = 3'd4
	} bcc_reg_t;

	typedef enum logic [2:0] {
		PH_IDLE     = 3'd0,
		PH_FIRST    = 3'd1,
		PH_RELEASED = 3'd2,
		PH_SECOND   = 3'd3,
		PH_HELD     = 3'd4
	} bcc_phase_t;

	typedef enum logic [EV_W-1:0] {
		EV_NONE   = 3'd0,
		EV_SHORT  = 3'd1,
		EV_DOUBLE = 3'd2,
		EV_LONG   = 3'd3,
		EV_HELD   = 3'd4
	} bcc_event_t;

	typedef struct packed {
		logic [DEB_W-1:0] debounce_ms;
		logic [THR_W-1:0] short_ms;
		logic [THR_W-1:0] long_ms;
		logic [THR_W-1:0] double_gap_ms;
		logic             active_low;
	} bcc_cfg_t;

endpackage

`default_nettype wire

// ===== hdl/bcc_if.sv =====
// valid/ready channel interfaces for button samples and classified results
// depends on bcc_pkg
`default_nettype none

interface bcc_sample_if;
	import bcc_pkg::*;
	logic             valid;
	logic             ready;
	logic             raw_level;
	logic [NOW_W-1:0] now_ms;

	modport source (output valid, output raw_level, output now_ms, input ready);
	modport sink   (input valid, input raw_level, input now_ms, output ready);
endinterface

interface bcc_result_if;
	import bcc_pkg::*;
	logic            valid;
	logic            ready;
	logic [EV_W-1:0] click_event;

	modport source (output valid, output click_event, input ready);
	modport sink   (input valid, input click_event, output ready);
endinterface

`default_nettype wire

// ===== hdl/bcc_cfg.sv =====
// configuration register file plus the precomputed hold threshold
// depends on bcc_pkg
`default_nettype none

module bcc_cfg #(
	parameter int HOLD_FACTOR = bcc_pkg::HOLD_FACTOR_DEF
) (
	input  wire logic                            clk,
	input  wire logic                            arst_n,
	input  wire logic                            cfg_we,
	input  wire logic [bcc_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  wire logic [bcc_pkg::CFG_DATA_W-1:0]  cfg_data,
	output bcc_pkg::bcc_cfg_t                    cfg,
	output logic [bcc_pkg::THR_W+$clog2(HOLD_FACTOR)-1:0] hold_ms
);
	import bcc_pkg::*;

	localparam int HoldW = THR_W + $clog2(HOLD_FACTOR);

	bcc_cfg_t          cfg_q;
	logic [HoldW-1:0]  hold_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.debounce_ms   <= DEB_RST;
			cfg_q.short_ms      <= SHORT_RST;
			cfg_q.long_ms       <= LONG_RST;
			cfg_q.double_gap_ms <= DGAP_RST;
			cfg_q.active_low    <= ALOW_RST;
			hold_q              <= HoldW'(HoldW'(LONG_RST) * HoldW'(HOLD_FACTOR));
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE:   cfg_q.debounce_ms   <= cfg_data[DEB_W-1:0];
				REG_SHORT:      cfg_q.short_ms      <= cfg_data[THR_W-1:0];
				REG_LONG: begin
					cfg_q.long_ms <= cfg_data[THR_W-1:0];
					// constant multiply, done once at write time
					hold_q <= HoldW'(HoldW'(cfg_data[THR_W-1:0]) * HoldW'(HOLD_FACTOR));
				end
				REG_DOUBLE_GAP: cfg_q.double_gap_ms <= cfg_data[THR_W-1:0];
				REG_ACTIVE_LOW: cfg_q.active_low    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg     = cfg_q;
	assign hold_ms = hold_q;

endmodule

`default_nettype wire

// ===== hdl/bcc_core.sv =====
// press/release phase machine with press-start and release timestamps
// depends on bcc_pkg
`default_nettype none

module bcc_core #(
	parameter int HOLD_FACTOR = bcc_pkg::HOLD_FACTOR_DEF
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire logic                          step,
	input  wire logic                          raw_level,
	input  wire logic [bcc_pkg::NOW_W-1:0]     now_ms,
	input  wire bcc_pkg::bcc_cfg_t             cfg,
	input  wire logic [bcc_pkg::THR_W+$clog2(HOLD_FACTOR)-1:0] hold_ms,
	output bcc_pkg::bcc_event_t                click_event
);
	import bcc_pkg::*;

	bcc_phase_t        phase_q, phase_d;
	logic [NOW_W-1:0]  start_q, start_d;
	logic [NOW_W-1:0]  rel_q, rel_d;

	logic              lvl;
	logic [NOW_W-1:0]  len, gap;
	logic              len_lt_deb, len_gt_deb, len_gt_short, len_gt_long, len_gt_hold;
	logic              gap_lt_dg, gap_gt_dg;

	assign lvl = raw_level ^ cfg.active_low;
	assign len = now_ms - start_q;
	assign gap = now_ms - rel_q;

	assign len_lt_deb   = len < NOW_W'(cfg.debounce_ms);
	assign len_gt_deb   = len > NOW_W'(cfg.debounce_ms);
	assign len_gt_short = len > NOW_W'(cfg.short_ms);
	assign len_gt_long  = len > NOW_W'(cfg.long_ms);
	assign len_gt_hold  = len > NOW_W'(hold_ms);
	assign gap_lt_dg    = gap < NOW_W'(cfg.double_gap_ms);
	assign gap_gt_dg    = gap > NOW_W'(cfg.double_gap_ms);

	// next state
	always_comb begin
		phase_d = phase_q;
		start_d = start_q;
		rel_d   = rel_q;
		case (phase_q)
			PH_IDLE: begin
				if (lvl) begin
					phase_d = PH_FIRST;
					start_d = now_ms;
				end
			end
			PH_FIRST: begin
				if (!lvl) begin
					if (!len_lt_deb && !len_gt_long && len_gt_short) begin
						phase_d = PH_RELEASED;
						rel_d   = now_ms;
					end else begin
						phase_d = PH_IDLE;
					end
				end else if (len_gt_hold) begin
					phase_d = PH_HELD;
				end
			end
			PH_HELD: begin
				if (!lvl) phase_d = PH_IDLE;
			end
			PH_RELEASED: begin
				if (lvl && gap_lt_dg) begin
					phase_d = PH_SECOND;
					start_d = now_ms;
				end else if (!lvl && gap_gt_dg) begin
					phase_d = PH_IDLE;
				end
			end
			default: begin
				// second press, and unused codes behave the same
				if (!lvl && len_gt_deb) phase_d = PH_IDLE;
			end
		endcase
		if (phase_d == PH_IDLE) begin
			start_d = '0;
			rel_d   = '0;
		end
	end

	// event for this sample
	always_comb begin
		click_event = EV_NONE;
		case (phase_q)
			PH_IDLE: click_event = EV_NONE;
			PH_FIRST: begin
				if (!lvl) begin
					if (!len_lt_deb && len_gt_long) click_event = EV_LONG;
				end else if (len_gt_hold) begin
					click_event = EV_HELD;
				end
			end
			PH_HELD: begin
				if (lvl && len_gt_hold) click_event = EV_HELD;
			end
			PH_RELEASED: begin
				if (!lvl && !gap_lt_dg && gap_gt_dg) click_event = EV_SHORT;
				else if (!lvl && gap_lt_dg && gap_gt_dg) click_event = EV_SHORT;
			end
			default: begin
				if (!lvl && len_gt_deb) click_event = EV_DOUBLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			start_q <= '0;
			rel_q   <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			start_q <= start_d;
			rel_q   <= rel_d;
		end
	end

endmodule

`default_nettype wire

// ===== hdl/button_click_classifier.sv =====
// top level of the button click classifier: input stage, phase machine, result register
// depends on bcc_pkg, bcc_if, bcc_cfg, bcc_core
//
// usage
//   sample channel: one button sample per transfer, raw pin level plus a free-running
//   millisecond timestamp that wraps at 2^32
//   result channel: exactly one click_event per sample, in order
//   (0 none, 1 short click, 2 double click, 3 long press, 4 held)
//   config port: cfg_we/cfg_index/cfg_data, written only while no sample is in flight;
//   unknown indexes are dropped
// timing
//   a sample transfer loads the input register; the phase machine then updates and the
//   event lands in the result register together, as soon as the result register can
//   take it, and result.valid rises with that load
//   throughput is one sample per cycle while the result is not stalled; the phase/timestamp
//   registers close their loop through combinational logic (two subtracts and a handful of 32-bit compares)
// reset
//   arst_n clears the phase machine to idle, zeroes both timestamps, restores the
//   register defaults and empties both pipeline stages
// backpressure
//   a stalled result holds in the result register; the input register still takes one
//   more sample, then sample.ready drops until the result transfers
`default_nettype none

module button_click_classifier #(
	parameter int HOLD_FACTOR = bcc_pkg::HOLD_FACTOR_DEF
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_we,
	input  wire logic [bcc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [bcc_pkg::CFG_DATA_W-1:0] cfg_data,
	bcc_sample_if.sink                          sample,
	bcc_result_if.source                        result
);
	import bcc_pkg::*;

	localparam int HoldW = THR_W + $clog2(HOLD_FACTOR);

	bcc_cfg_t         cfg;
	logic [HoldW-1:0] hold_ms;

	// input stage
	logic             valid_s1;
	logic             level_s1;
	logic [NOW_W-1:0] now_s1;

	// result stage
	logic             out_valid_q;
	bcc_event_t       out_event_q;

	bcc_event_t       event_d;
	logic             advance;
	logic             step;

	// result register can take a new event when empty or draining this cycle
	assign advance      = !out_valid_q || result.ready;
	assign step         = valid_s1 && advance;
	assign sample.ready = !valid_s1 || advance;

	bcc_cfg #(
		.HOLD_FACTOR(HOLD_FACTOR)
	) u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.hold_ms   (hold_ms)
	);

	bcc_core #(
		.HOLD_FACTOR(HOLD_FACTOR)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.raw_level   (level_s1),
		.now_ms      (now_s1),
		.cfg         (cfg),
		.hold_ms     (hold_ms),
		.click_event (event_d)
	);

	// input register, valid bit under reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	// payload needs no reset
	always_ff @(posedge clk) begin
		if (sample.ready && sample.valid) begin
			level_s1 <= sample.raw_level;
			now_s1   <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) out_event_q <= event_d;
	end

	assign result.valid       = out_valid_q;
	assign result.click_event = out_event_q;

endmodule

`default_nettype wire

// ===== hdl/bcc_chk.sv =====
// port-level checker for the button click classifier, bound to the top level
// depends on bcc_pkg and button_click_classifier
`default_nettype none

module bcc_chk (
	input wire logic                    clk,
	input wire logic                    arst_n,
	input wire logic                    sample_valid,
	input wire logic                    sample_ready,
	input wire logic                    result_valid,
	input wire logic                    result_ready,
	input wire logic [bcc_pkg::EV_W-1:0] result_event
);
	import bcc_pkg::*;

	// a stalled result keeps its event
	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result_event))
		else $error("result changed while stalled");

	// only the five defined event codes leave the block
	a_event_code: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> (result_event == EV_NONE || result_event == EV_SHORT ||
			result_event == EV_DOUBLE || result_event == EV_LONG ||
			result_event == EV_HELD))
		else $error("undefined click event code");

	// input only backs up behind a waiting result
	a_ready_low: assert property (@(posedge clk) disable iff (!arst_n)
		!sample_ready |-> result_valid)
		else $error("sample stalled with empty result register");

	// every transfer in shows a valid result once it has passed the input and result registers
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		sample_valid && sample_ready |-> ##2 result_valid)
		else $error("no result two cycles after sample transfer");

endmodule

bind button_click_classifier bcc_chk u_bcc_chk (
	.clk          (clk),
	.arst_n       (arst_n),
	.sample_valid (sample.valid),
	.sample_ready (sample.ready),
	.result_valid (result.valid),
	.result_ready (result.ready),
	.result_event (result.click_event)
);

`default_nettype wire
